// ===== hw/rtl/bhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared constants, codes and types for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int REQ_W    = 3;
  localparam int IDX_W    = 10;
  localparam int STAT_W   = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EXTRACT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHANGE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BUILD   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_CHG_OLD,
    S_UP_RD,
    S_UP_CMP,
    S_UP_LD,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_BUILD,
    S_BLD_LD,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/bhq_if.sv =====
// ----------------------------------------------------------------------------
// bhq_if
// Request and response channels of the heap queue: valid/ready handshake.
// ----------------------------------------------------------------------------
interface bhq_req_if;
  logic                              valid;
  logic                              ready;
  logic [bhq_pkg::REQ_W-1:0]         req_type;
  logic signed [bhq_pkg::KEY_W-1:0]  key;
  logic [bhq_pkg::IDX_W-1:0]         index;

  modport source (output valid, req_type, key, index, input ready);
  modport sink   (input valid, req_type, key, index, output ready);
endinterface

interface bhq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [bhq_pkg::KEY_W-1:0]  extracted_key;
  logic signed [bhq_pkg::KEY_W-1:0]  min_key;
  logic [bhq_pkg::CNT_W-1:0]         entry_total;
  logic [bhq_pkg::STAT_W-1:0]        status;

  modport source (output valid, extracted_key, min_key, entry_total, status, input ready);
  modport sink   (input valid, extracted_key, min_key, entry_total, status, output ready);
endinterface

// ===== hw/rtl/bhq_ram.sv =====
// ----------------------------------------------------------------------------
// bhq_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bhq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhq_ctrl
// Request sequencer: sift-up / sift-down walks over the heap RAM, output reg.
// ----------------------------------------------------------------------------
module bhq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  bhq_req_if.sink                     req,
  bhq_rsp_if.source                   rsp,
  output bhq_pkg::ram_req_t           ram,
  input  logic [bhq_pkg::KEY_W-1:0]   ram_rdata
);

  localparam int ADDR_W = bhq_pkg::ADDR_W;
  localparam int CNT_W  = bhq_pkg::CNT_W;
  localparam int KEY_W  = bhq_pkg::KEY_W;

  bhq_pkg::state_t state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [ADDR_W-1:0]       pos, pos_next;
  logic [ADDR_W-1:0]       start_pos, start_pos_next;
  logic [ADDR_W-1:0]       best_pos, best_pos_next;
  logic [ADDR_W-1:0]       build_i, build_i_next;
  logic signed [KEY_W-1:0] cur_key, cur_key_next;
  logic signed [KEY_W-1:0] best_key, best_key_next;
  logic signed [KEY_W-1:0] extracted, extracted_next;
  logic [bhq_pkg::STAT_W-1:0] status, status_next;
  logic                    up_after, up_after_next;
  logic                    building, building_next;
  logic                    has_r, has_r_next;
  logic                    out_valid, out_valid_next;
  logic signed [KEY_W-1:0] out_ext, out_ext_next;
  logic signed [KEY_W-1:0] out_min, out_min_next;
  logic [CNT_W-1:0]        out_total, out_total_next;
  logic [bhq_pkg::STAT_W-1:0] out_status, out_status_next;

  logic signed [KEY_W-1:0] rkey;
  logic [CNT_W:0]          lchild, rchild;
  logic [ADDR_W-1:0]       pos_m1, parent;
  logic [CNT_W-1:0]        count_m1;
  logic                    accept;

  assign rkey     = ram_rdata;
  assign lchild   = {1'b0, pos, 1'b1};
  assign rchild   = lchild + 1'b1;
  assign pos_m1   = pos - 1'b1;
  assign parent   = {1'b0, pos_m1[ADDR_W-1:1]};
  assign count_m1 = count - 1'b1;
  assign accept   = req.valid && req.ready;

  assign req.ready         = (state == bhq_pkg::S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.extracted_key = out_ext;
  assign rsp.min_key       = out_min;
  assign rsp.entry_total   = out_total;
  assign rsp.status        = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bhq_pkg::S_IDLE;
      count     <= '0;
      up_after  <= 1'b0;
      building  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      up_after  <= up_after_next;
      building  <= building_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    start_pos  <= start_pos_next;
    best_pos   <= best_pos_next;
    build_i    <= build_i_next;
    cur_key    <= cur_key_next;
    best_key   <= best_key_next;
    extracted  <= extracted_next;
    status     <= status_next;
    has_r      <= has_r_next;
    out_ext    <= out_ext_next;
    out_min    <= out_min_next;
    out_total  <= out_total_next;
    out_status <= out_status_next;
  end

  always_comb begin
    logic signed [KEY_W-1:0] bk;
    logic [ADDR_W-1:0]       bp;
    logic                    down_done;

    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    start_pos_next  = start_pos;
    best_pos_next   = best_pos;
    build_i_next    = build_i;
    cur_key_next    = cur_key;
    best_key_next   = best_key;
    extracted_next  = extracted;
    status_next     = status;
    up_after_next   = up_after;
    building_next   = building;
    has_r_next      = has_r;
    out_valid_next  = out_valid;
    out_ext_next    = out_ext;
    out_min_next    = out_min;
    out_total_next  = out_total;
    out_status_next = out_status;
    ram             = '0;
    bk              = best_key;
    bp              = best_pos;
    down_done       = 1'b0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      bhq_pkg::S_IDLE: begin
        if (accept) begin
          extracted_next = '0;
          status_next    = bhq_pkg::ST_OK;
          state_next     = bhq_pkg::S_FINISH;
          case (req.req_type)
            bhq_pkg::REQ_INSERT, bhq_pkg::REQ_APPEND: begin
              if (count == CNT_W'(bhq_pkg::CAPACITY)) begin
                status_next = bhq_pkg::ST_FULL;
              end else if (req.req_type == bhq_pkg::REQ_APPEND) begin
                ram.we     = 1'b1;
                ram.waddr  = count[ADDR_W-1:0];
                ram.wdata  = req.key;
                count_next = count + 1'b1;
              end else begin
                pos_next     = count[ADDR_W-1:0];
                cur_key_next = req.key;
                count_next   = count + 1'b1;
                state_next   = bhq_pkg::S_UP_RD;
              end
            end
            bhq_pkg::REQ_EXTRACT: begin
              if (count == '0) begin
                status_next = bhq_pkg::ST_EMPTY;
              end else begin
                ram.re     = 1'b1;
                ram.raddr  = '0;
                count_next = count_m1;
                state_next = bhq_pkg::S_EXT_ROOT;
              end
            end
            bhq_pkg::REQ_CHANGE: begin
              if (CNT_W'(req.index) >= count) begin
                status_next = bhq_pkg::ST_RANGE;
              end else begin
                ram.re         = 1'b1;
                ram.raddr      = ADDR_W'(req.index);
                pos_next       = ADDR_W'(req.index);
                start_pos_next = ADDR_W'(req.index);
                cur_key_next   = req.key;
                state_next     = bhq_pkg::S_CHG_OLD;
              end
            end
            bhq_pkg::REQ_BUILD: begin
              build_i_next  = count[CNT_W-1:1];
              building_next = 1'b1;
              state_next    = bhq_pkg::S_BUILD;
            end
            default: ;
          endcase
        end
      end

      bhq_pkg::S_EXT_ROOT: begin
        extracted_next = rkey;
        ram.re         = 1'b1;
        ram.raddr      = count[ADDR_W-1:0];
        state_next     = bhq_pkg::S_EXT_LAST;
      end

      bhq_pkg::S_EXT_LAST: begin
        cur_key_next = rkey;
        pos_next     = '0;
        state_next   = bhq_pkg::S_DN_L;
      end

      bhq_pkg::S_CHG_OLD: begin
        if (rkey < cur_key) begin
          up_after_next = 1'b1;
          state_next    = bhq_pkg::S_DN_L;
        end else begin
          state_next = bhq_pkg::S_UP_RD;
        end
      end

      // hole-based sift up: cur_key is written once at its final slot
      bhq_pkg::S_UP_RD: begin
        if (pos == '0) begin
          ram.we     = 1'b1;
          ram.waddr  = pos;
          ram.wdata  = cur_key;
          state_next = bhq_pkg::S_FINISH;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = parent;
          state_next = bhq_pkg::S_UP_CMP;
        end
      end

      bhq_pkg::S_UP_CMP: begin
        ram.we    = 1'b1;
        ram.waddr = pos;
        if (rkey > cur_key) begin
          ram.wdata  = rkey;
          pos_next   = parent;
          state_next = bhq_pkg::S_UP_RD;
        end else begin
          ram.wdata  = cur_key;
          state_next = bhq_pkg::S_FINISH;
        end
      end

      bhq_pkg::S_UP_LD: begin
        cur_key_next = rkey;
        pos_next     = start_pos;
        state_next   = bhq_pkg::S_UP_RD;
      end

      bhq_pkg::S_DN_L: begin
        if (lchild >= {1'b0, count}) begin
          down_done = 1'b1;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = lchild[ADDR_W-1:0];
          has_r_next = (rchild < {1'b0, count});
          state_next = bhq_pkg::S_DN_R;
        end
      end

      bhq_pkg::S_DN_R: begin
        if (rkey < cur_key) begin
          best_key_next = rkey;
          best_pos_next = lchild[ADDR_W-1:0];
        end else begin
          best_key_next = cur_key;
          best_pos_next = pos;
        end
        if (has_r) begin
          ram.re    = 1'b1;
          ram.raddr = rchild[ADDR_W-1:0];
        end
        state_next = bhq_pkg::S_DN_CMP;
      end

      bhq_pkg::S_DN_CMP: begin
        if (has_r && (rkey < best_key)) begin
          bk = rkey;
          bp = rchild[ADDR_W-1:0];
        end
        if (bp == pos) begin
          down_done = 1'b1;
        end else begin
          ram.we     = 1'b1;
          ram.waddr  = pos;
          ram.wdata  = bk;
          pos_next   = bp;
          state_next = bhq_pkg::S_DN_L;
        end
      end

      bhq_pkg::S_BUILD: begin
        if (build_i == '0) begin
          building_next = 1'b0;
          state_next    = bhq_pkg::S_FINISH;
        end else begin
          build_i_next = build_i - 1'b1;
          pos_next     = build_i - 1'b1;
          ram.re       = 1'b1;
          ram.raddr    = build_i - 1'b1;
          state_next   = bhq_pkg::S_BLD_LD;
        end
      end

      bhq_pkg::S_BLD_LD: begin
        cur_key_next = rkey;
        state_next   = bhq_pkg::S_DN_L;
      end

      bhq_pkg::S_FINISH: begin
        ram.re     = 1'b1;
        ram.raddr  = '0;
        state_next = bhq_pkg::S_RESULT;
      end

      bhq_pkg::S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_ext_next    = extracted;
          out_min_next    = (count != '0) ? rkey : '0;
          out_total_next  = count;
          out_status_next = status;
          state_next      = bhq_pkg::S_IDLE;
        end
      end

      default: state_next = bhq_pkg::S_IDLE;
    endcase

    // end of a sift down: park cur_key and pick the follow-up
    if (down_done) begin
      ram.we    = 1'b1;
      ram.waddr = pos;
      ram.wdata = cur_key;
      if (up_after) begin
        up_after_next = 1'b0;
        if (pos == start_pos) begin
          state_next = bhq_pkg::S_UP_RD;
        end else begin
          ram.re     = 1'b1;
          ram.raddr  = start_pos;
          state_next = bhq_pkg::S_UP_LD;
        end
      end else if (building) begin
        state_next = bhq_pkg::S_BUILD;
      end else begin
        state_next = bhq_pkg::S_FINISH;
      end
    end
  end

endmodule

// ===== hw/rtl/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of signed keys held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries req_type, key and index; one transaction is one
//   request. rsp channel returns exactly one result per request with the
//   extracted key, the root key, the entry count and a status code.
//   Requests are served one at a time. A request then runs the sift walk
//   through the heap RAM, which has a single read port: each level going up
//   passes through S_UP_RD and S_UP_CMP, each level going down through
//   S_DN_L, S_DN_R and S_DN_CMP. Build runs a sift down from every inner
//   node. The result sits in an output register; the next request is taken
//   while it waits, and a stalled receiver only holds the block at the end
//   of that next request. Reset empties the queue at once (no clearing
//   pass); heap RAM contents are unknown until written, and no value read
//   from them is used before.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
  input  logic      clk,
  input  logic      rst,
  bhq_req_if.sink   req,
  bhq_rsp_if.source rsp
);

  bhq_pkg::ram_req_t            ram;
  logic [bhq_pkg::KEY_W-1:0]    ram_rdata;

  bhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .ram       (ram),
    .ram_rdata (ram_rdata)
  );

  bhq_ram #(
    .DEPTH (bhq_pkg::CAPACITY),
    .WIDTH (bhq_pkg::KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

endmodule
